@@ sv/vrp_pkg.sv @@
// ---------------------------------------------------------------------------
// vrp_pkg: shared types and constants for the vertex rotate/project block
// Number formats, stage widths, register map and beat structs.
// ---------------------------------------------------------------------------
package vrp_pkg;

  // number formats
  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 12;
  localparam int TRIG_FRAC   = 14;
  localparam int TRIG_W      = 16;
  localparam int DIST_W      = 15;
  localparam int COLOR_W     = 8;

  // intermediate widths, all exact
  localparam int YP_W  = COORD_WIDTH + TRIG_W;      // yaw products
  localparam int YS_W  = YP_W + 2;                  // yaw sums with rounding headroom
  localparam int R1_W  = YS_W - TRIG_FRAC;          // x1, z1
  localparam int PP_W  = R1_W + TRIG_W;             // pitch products
  localparam int PS_W  = PP_W + 2;                  // pitch sums
  localparam int R2_W  = PS_W - TRIG_FRAC;          // y1, z2
  localparam int DEN_W = R2_W + 1;                  // distance + z2
  localparam int NUM_W = R2_W + DIST_W + 1;         // coordinate * distance
  localparam int N_W   = NUM_W + 2;                 // 2*num + den, and its magnitude
  localparam int DIV_W = DEN_W + 1;                 // divisor 2*den
  localparam int QB    = COORD_WIDTH + FRAC_BITS + 1; // quotient bits, one per stage
  localparam int Q_W   = QB + 1;                    // signed clamped quotient
  localparam int SP_W  = Q_W + DIST_W + 1;          // quotient * fov gain

  // pipeline depth
  localparam int ROT_STAGES = 4;
  localparam int PRJ_STAGES = QB + 6;
  localparam int LATENCY    = ROT_STAGES + PRJ_STAGES;

  // register map
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COS_YAW   = 3'd0,
    REG_SIN_YAW   = 3'd1,
    REG_COS_PITCH = 3'd2,
    REG_SIN_PITCH = 3'd3,
    REG_CAM_DIST  = 3'd4,
    REG_FOV_GAIN  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_yaw;
    logic signed [TRIG_W-1:0] sin_yaw;
    logic signed [TRIG_W-1:0] cos_pitch;
    logic signed [TRIG_W-1:0] sin_pitch;
    logic        [DIST_W-1:0] cam_dist;
    logic        [DIST_W-1:0] fov_gain;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    cos_yaw:   16'sd16384,
    sin_yaw:   16'sd0,
    cos_pitch: 16'sd16384,
    sin_pitch: 16'sd0,
    cam_dist:  15'd12288,
    fov_gain:  15'd6144
  };

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] model_x;
    logic signed [COORD_WIDTH-1:0] model_y;
    logic signed [COORD_WIDTH-1:0] model_z;
    logic        [COLOR_W-1:0]     red_in;
    logic        [COLOR_W-1:0]     green_in;
    logic        [COLOR_W-1:0]     blue_in;
  } in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] screen_x;
    logic signed [COORD_WIDTH-1:0] screen_y;
    logic        [COLOR_W-1:0]     red_out;
    logic        [COLOR_W-1:0]     green_out;
    logic        [COLOR_W-1:0]     blue_out;
    logic                          behind_camera;
  } out_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

  // rotated vertex handed from the rotate stages to the projection stages
  typedef struct packed {
    logic signed [R2_W-1:0] x1;
    logic signed [R2_W-1:0] y1;
    logic signed [R2_W-1:0] z2;
    color_t                 color;
  } rot_t;

  // sideband that rides alongside the divider
  typedef struct packed {
    logic   behind;
    logic   neg_x;
    logic   neg_y;
    logic   ovf_x;
    logic   ovf_y;
    color_t color;
  } side_t;

endpackage

@@ sv/vrp_regs.sv @@
// ---------------------------------------------------------------------------
// vrp_regs: configuration register file
// APB-style write/read of the trig, distance and gain registers.
// ---------------------------------------------------------------------------
module vrp_regs
  import vrp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_COS_YAW:   cfg_nxt.cos_yaw   = pwdata[TRIG_W-1:0];
        REG_SIN_YAW:   cfg_nxt.sin_yaw   = pwdata[TRIG_W-1:0];
        REG_COS_PITCH: cfg_nxt.cos_pitch = pwdata[TRIG_W-1:0];
        REG_SIN_PITCH: cfg_nxt.sin_pitch = pwdata[TRIG_W-1:0];
        REG_CAM_DIST:  cfg_nxt.cam_dist  = pwdata[DIST_W-1:0];
        REG_FOV_GAIN:  cfg_nxt.fov_gain  = pwdata[DIST_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux, signed registers come back sign extended
  always_comb begin
    case (idx)
      REG_COS_YAW:   prdata = 32'(cfg_r.cos_yaw);
      REG_SIN_YAW:   prdata = 32'(cfg_r.sin_yaw);
      REG_COS_PITCH: prdata = 32'(cfg_r.cos_pitch);
      REG_SIN_PITCH: prdata = 32'(cfg_r.sin_pitch);
      REG_CAM_DIST:  prdata = 32'(cfg_r.cam_dist);
      REG_FOV_GAIN:  prdata = 32'(cfg_r.fov_gain);
      default:       prdata = '0;
    endcase
  end

endmodule

@@ sv/vrp_rotate.sv @@
// ---------------------------------------------------------------------------
// vrp_rotate: yaw then pitch rotation
// Four stages: yaw products, yaw round, pitch products, pitch round.
// ---------------------------------------------------------------------------
module vrp_rotate
  import vrp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_vld,
  input  in_t  in_beat,
  input  cfg_t cfg,
  output logic rot_vld,
  output rot_t rot_beat
);

  localparam logic signed [YS_W-1:0] YS_HALF = YS_W'(1) << (TRIG_FRAC - 1);
  localparam logic signed [PS_W-1:0] PS_HALF = PS_W'(1) << (TRIG_FRAC - 1);

  // stage 1: yaw products
  logic                          v1_r;
  logic signed [YP_W-1:0]        pxc_r, pzs_r, pxs_r, pzc_r;
  logic signed [COORD_WIDTH-1:0] y1_r;
  color_t                        col1_r;

  // stage 2: x1, z1
  logic                          v2_r;
  logic signed [R1_W-1:0]        x1_2_r, z1_2_r;
  logic signed [COORD_WIDTH-1:0] y2_r;
  color_t                        col2_r;
  logic signed [YS_W-1:0]        x1_sum, z1_sum;

  // stage 3: pitch products
  logic                          v3_r;
  logic signed [PP_W-1:0]        ycp_r, zsp_r, ysp_r, zcp_r;
  logic signed [R1_W-1:0]        x1_3_r;
  color_t                        col3_r;

  // stage 4: y1, z2
  logic                          v4_r;
  rot_t                          rot_r;
  logic signed [PS_W-1:0]        y1_sum, z2_sum;

  // valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // yaw products
  always_ff @(posedge clk) begin
    pxc_r  <= YP_W'(in_beat.model_x) * YP_W'(cfg.cos_yaw);
    pzs_r  <= YP_W'(in_beat.model_z) * YP_W'(cfg.sin_yaw);
    pxs_r  <= YP_W'(in_beat.model_x) * YP_W'(cfg.sin_yaw);
    pzc_r  <= YP_W'(in_beat.model_z) * YP_W'(cfg.cos_yaw);
    y1_r   <= in_beat.model_y;
    col1_r <= '{red: in_beat.red_in, green: in_beat.green_in, blue: in_beat.blue_in};
  end

  // yaw sums, round to nearest
  always_comb begin
    x1_sum = YS_W'(pxc_r) - YS_W'(pzs_r) + YS_HALF;
    z1_sum = YS_W'(pxs_r) + YS_W'(pzc_r) + YS_HALF;
  end

  always_ff @(posedge clk) begin
    x1_2_r <= R1_W'(x1_sum >>> TRIG_FRAC);
    z1_2_r <= R1_W'(z1_sum >>> TRIG_FRAC);
    y2_r   <= y1_r;
    col2_r <= col1_r;
  end

  // pitch products
  always_ff @(posedge clk) begin
    ycp_r  <= PP_W'(y2_r) * PP_W'(cfg.cos_pitch);
    zsp_r  <= PP_W'(z1_2_r) * PP_W'(cfg.sin_pitch);
    ysp_r  <= PP_W'(y2_r) * PP_W'(cfg.sin_pitch);
    zcp_r  <= PP_W'(z1_2_r) * PP_W'(cfg.cos_pitch);
    x1_3_r <= x1_2_r;
    col3_r <= col2_r;
  end

  // pitch sums, round to nearest
  always_comb begin
    y1_sum = PS_W'(ycp_r) - PS_W'(zsp_r) + PS_HALF;
    z2_sum = PS_W'(ysp_r) + PS_W'(zcp_r) + PS_HALF;
  end

  always_ff @(posedge clk) begin
    rot_r.x1    <= R2_W'(x1_3_r);
    rot_r.y1    <= R2_W'(y1_sum >>> TRIG_FRAC);
    rot_r.z2    <= R2_W'(z2_sum >>> TRIG_FRAC);
    rot_r.color <= col3_r;
  end

  assign rot_vld  = v4_r;
  assign rot_beat = rot_r;

endmodule

@@ sv/vrp_div.sv @@
// ---------------------------------------------------------------------------
// vrp_div: pipelined restoring divider
// One quotient bit per stage, unsigned magnitude over divisor, QB stages.
// ---------------------------------------------------------------------------
module vrp_div
  import vrp_pkg::*;
(
  input  logic             clk,
  input  logic [N_W-1:0]   mag_i,
  input  logic [DIV_W-1:0] dvs_i,
  output logic [QB-1:0]    quo_o
);

  logic [DIV_W-1:0] rem_r [QB];
  logic [QB-1:0]    quo_r [QB];
  logic [N_W-1:0]   mag_r [QB];
  logic [DIV_W-1:0] dvs_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [DIV_W-1:0] rem_in;
    logic [DIV_W-1:0] dvs_in;
    logic [QB-1:0]    quo_in;
    logic [N_W-1:0]   mag_in;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;

    if (k == 0) begin : g_first
      // high part of the dividend starts the partial remainder
      assign rem_in = DIV_W'(mag_i >> QB);
      assign quo_in = '0;
      assign mag_in = mag_i;
      assign dvs_in = dvs_i;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
      assign mag_in = mag_r[k-1];
      assign dvs_in = dvs_r[k-1];
    end

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_in, mag_in[QB-1-k]};
    assign diff  = trial - {1'b0, dvs_in};
    assign fits  = ~diff[DIV_W];

    always_ff @(posedge clk) begin
      rem_r[k] <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_r[k] <= quo_in | (QB'(fits) << (QB - 1 - k));
      mag_r[k] <= mag_in;
      dvs_r[k] <= dvs_in;
    end
  end

  assign quo_o = quo_r[QB-1];

endmodule

@@ sv/vrp_project.sv @@
// ---------------------------------------------------------------------------
// vrp_project: perspective divide, fov gain and saturation
// Numerators, divisor prep, two dividers, clamp, gain multiply, output reg.
// ---------------------------------------------------------------------------
module vrp_project
  import vrp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic rot_vld,
  input  rot_t rot_beat,
  input  cfg_t cfg,
  output logic out_vld,
  output out_t out_beat
);

  localparam logic [QB-1:0] Q_LIM = {1'b1, {(QB - 1){1'b0}}};
  localparam logic signed [SP_W-1:0] SP_HALF = SP_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SP_W-1:0] SAT_HI =
    {{(SP_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [SP_W-1:0] SAT_LO = ~SAT_HI;

  // clamp the quotient magnitude and apply its sign
  function automatic logic signed [Q_W-1:0] clamp_q(input logic [QB-1:0] quo,
                                                    input logic ovf,
                                                    input logic neg);
    logic [QB-1:0] mag;
    mag = (ovf || (quo > Q_LIM)) ? Q_LIM : quo;
    return neg ? -$signed(Q_W'(mag)) : $signed(Q_W'(mag));
  endfunction

  // round away the gain fraction and saturate
  function automatic logic signed [COORD_WIDTH-1:0] scale_sat(
    input logic signed [SP_W-1:0] prod);
    logic signed [SP_W-1:0] t;
    t = (prod + SP_HALF) >>> FRAC_BITS;
    if (t > SAT_HI) begin
      return SAT_HI[COORD_WIDTH-1:0];
    end else if (t < SAT_LO) begin
      return SAT_LO[COORD_WIDTH-1:0];
    end
    return t[COORD_WIDTH-1:0];
  endfunction

  logic signed [DIST_W:0]  dist_s;
  logic signed [DIST_W:0]  gain_s;

  // stage 0: numerators and denominator
  logic                    v0_r;
  logic signed [NUM_W-1:0] num_x_r, num_y_r;
  logic signed [DEN_W-1:0] den_r;
  color_t                  col0_r;

  // stage 1: rounding dividends and divisor
  logic                    v1_r;
  logic signed [N_W-1:0]   n_x_r, n_y_r;
  logic [DIV_W-1:0]        dvs1_r;
  logic                    behind1_r;
  color_t                  col1_r;

  // stage 2: magnitudes and overflow check
  logic                    v2_r;
  logic [N_W-1:0]          mag_x_r, mag_y_r;
  logic [DIV_W-1:0]        dvs2_r;
  side_t                   side2_r;
  logic [N_W-1:0]          mag_x, mag_y;

  // divider span
  logic [QB-1:0]           vld_d_r;
  side_t                   side_d_r [QB];
  logic [QB-1:0]           quo_x, quo_y;

  // stage 3: clamped signed quotients
  logic                    v3_r;
  logic signed [Q_W-1:0]   q_x_r, q_y_r;
  side_t                   side3_r;

  // stage 4: gain products
  logic                    v4_r;
  logic signed [SP_W-1:0]  sp_x_r, sp_y_r;
  side_t                   side4_r;

  // stage 5: output register
  logic                    out_vld_r;
  out_t                    out_r;

  assign dist_s = $signed({1'b0, cfg.cam_dist});
  assign gain_s = $signed({1'b0, cfg.fov_gain});

  // valid line through every stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r      <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      vld_d_r   <= '0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      v0_r      <= rot_vld;
      v1_r      <= v0_r;
      v2_r      <= v1_r;
      vld_d_r   <= {vld_d_r[QB-2:0], v2_r};
      v3_r      <= vld_d_r[QB-1];
      v4_r      <= v3_r;
      out_vld_r <= v4_r;
    end
  end

  // numerators scaled by distance, denominator distance + z2
  always_ff @(posedge clk) begin
    num_x_r <= NUM_W'(rot_beat.x1) * NUM_W'(dist_s);
    num_y_r <= NUM_W'(rot_beat.y1) * NUM_W'(dist_s);
    den_r   <= DEN_W'(rot_beat.z2) + DEN_W'(dist_s);
    col0_r  <= rot_beat.color;
  end

  // round-to-nearest form: floor((2n + d) / 2d)
  always_ff @(posedge clk) begin
    n_x_r     <= (N_W'(num_x_r) <<< 1) + N_W'(den_r);
    n_y_r     <= (N_W'(num_y_r) <<< 1) + N_W'(den_r);
    dvs1_r    <= DIV_W'(den_r) << 1;
    behind1_r <= den_r[DEN_W-1] || (den_r == '0);
    col1_r    <= col0_r;
  end

  // negative dividend: ceil of magnitude via ~n + 2d, i.e. |n| + 2d - 1
  always_comb begin
    mag_x = n_x_r[N_W-1] ? (~n_x_r + N_W'(dvs1_r)) : n_x_r;
    mag_y = n_y_r[N_W-1] ? (~n_y_r + N_W'(dvs1_r)) : n_y_r;
  end

  always_ff @(posedge clk) begin
    mag_x_r       <= mag_x;
    mag_y_r       <= mag_y;
    dvs2_r        <= dvs1_r;
    side2_r.behind <= behind1_r;
    side2_r.neg_x <= n_x_r[N_W-1];
    side2_r.neg_y <= n_y_r[N_W-1];
    side2_r.ovf_x <= (mag_x >> QB) >= N_W'(dvs1_r);
    side2_r.ovf_y <= (mag_y >> QB) >= N_W'(dvs1_r);
    side2_r.color <= col1_r;
  end

  vrp_div u_div_x (
    .clk   (clk),
    .mag_i (mag_x_r),
    .dvs_i (dvs2_r),
    .quo_o (quo_x)
  );

  vrp_div u_div_y (
    .clk   (clk),
    .mag_i (mag_y_r),
    .dvs_i (dvs2_r),
    .quo_o (quo_y)
  );

  // sideband delay matching the dividers
  always_ff @(posedge clk) begin
    side_d_r[0] <= side2_r;
    for (int k = 1; k < QB; k++) begin
      side_d_r[k] <= side_d_r[k-1];
    end
  end

  // clamp and sign
  always_ff @(posedge clk) begin
    q_x_r   <= clamp_q(quo_x, side_d_r[QB-1].ovf_x, side_d_r[QB-1].neg_x);
    q_y_r   <= clamp_q(quo_y, side_d_r[QB-1].ovf_y, side_d_r[QB-1].neg_y);
    side3_r <= side_d_r[QB-1];
  end

  // field-of-view gain
  always_ff @(posedge clk) begin
    sp_x_r  <= SP_W'(q_x_r) * SP_W'(gain_s);
    sp_y_r  <= SP_W'(q_y_r) * SP_W'(gain_s);
    side4_r <= side3_r;
  end

  // saturate, zero the position behind the camera
  always_ff @(posedge clk) begin
    out_r.screen_x      <= side4_r.behind ? '0 : scale_sat(sp_x_r);
    out_r.screen_y      <= side4_r.behind ? '0 : scale_sat(sp_y_r);
    out_r.red_out       <= side4_r.color.red;
    out_r.green_out     <= side4_r.color.green;
    out_r.blue_out      <= side4_r.color.blue;
    out_r.behind_camera <= side4_r.behind;
  end

  assign out_vld  = out_vld_r;
  assign out_beat = out_r;

endmodule

@@ sv/vertex_rotate_project.sv @@
// ---------------------------------------------------------------------------
// vertex_rotate_project: vertex rotation and perspective projection
// Pipeline: 4 rotate stages, 3 prep stages, 29 divider stages, 3 output
// stages.
// Throughput: one vertex per cycle; busy is never raised, the dividers are
// fully pipelined with one quotient bit per stage.
// Reset: synchronous active-low rst_n clears all valid bits and loads the
// register defaults; results cannot be held off by the receiver.
// ---------------------------------------------------------------------------
module vertex_rotate_project
  import vrp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // vertex input
  input  logic              start,
  output logic              busy,
  input  in_t               in_data,
  // projected result
  output logic              out_strobe,
  output out_t              out_data,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg;
  logic in_vld;
  logic rot_vld;
  rot_t rot_beat;

  // fully pipelined: always ready
  assign busy   = 1'b0;
  assign in_vld = start && !busy;

  vrp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vrp_rotate u_rotate (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld),
    .in_beat  (in_data),
    .cfg      (cfg),
    .rot_vld  (rot_vld),
    .rot_beat (rot_beat)
  );

  vrp_project u_project (
    .clk      (clk),
    .rst_n    (rst_n),
    .rot_vld  (rot_vld),
    .rot_beat (rot_beat),
    .cfg      (cfg),
    .out_vld  (out_strobe),
    .out_beat (out_data)
  );

  // every accepted beat yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_strobe)
    else $error("result missing after accepted vertex");

  // no result without a beat accepted the same latency earlier
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LATENCY))
    else $error("result without a matching vertex");

  // red and blue travel with their vertex
  a_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.red_out == $past(in_data.red_in, LATENCY)) &&
                   (out_data.blue_out == $past(in_data.blue_in, LATENCY)))
    else $error("color misaligned with position");

  // vertices behind the camera project to the origin
  a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.behind_camera) |->
      (out_data.screen_x == '0) && (out_data.screen_y == '0))
    else $error("nonzero position behind camera");

endmodule
